FILE: sv/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_INS_AT    = 3'd2;
	localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [2:0] ACT_DEL_AT    = 3'd5;
	localparam logic [2:0] ACT_DUMP      = 3'd6;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_DELETE = 2'd2;
	localparam logic [1:0] CELL_ROTATE = 2'd3;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [7:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         element_count;
		logic signed [31:0] element_value;
		logic               has_element;
		logic               last;
	} res_t;

endpackage

FILE: sv/ple_if.sv
// Request and result channel interfaces with valid/ready handshake.
interface ple_cmd_if;
	logic          valid;
	logic          ready;
	ple_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ple_res_if;
	logic          valid;
	logic          ready;
	ple_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/ple_cell.sv
// One storage cell of the list row; loads a neighbor, insert or head value.
module ple_cell #(
	parameter int IW    = 4,
	parameter int INDEX = 0
) (
	input  logic                 clk,
	input  logic [1:0]           op,
	input  logic [IW-1:0]        at,
	input  logic [IW-1:0]        tail,
	input  logic signed [31:0]   ins_value,
	input  logic signed [31:0]   left_value,
	input  logic signed [31:0]   right_value,
	input  logic signed [31:0]   head_value,
	output logic signed [31:0]   value
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic signed [31:0] value_q;
	logic signed [31:0] value_d;

	always_comb begin
		value_d = value_q;
		unique case (op)
			ple_pkg::CELL_HOLD: value_d = value_q;
			ple_pkg::CELL_INSERT: begin
				if (MY_IDX > at) value_d = left_value;
				else if (MY_IDX == at) value_d = ins_value;
			end
			ple_pkg::CELL_DELETE: begin
				if (MY_IDX >= at) value_d = right_value;
			end
			ple_pkg::CELL_ROTATE: begin
				if (MY_IDX < tail) value_d = right_value;
				else if (MY_IDX == tail) value_d = head_value;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

FILE: sv/positional_list_engine_core.sv
// Positional list engine: a packed row of cells holding an ordered list of signed values.
// Insert and delete requests update the row at once: every cell shifts toward or away from
// its neighbor and a single result is registered in the cycle after the request is taken. A
// dump walks the list by rotating the occupied cells one place per cycle while the result
// register is free or drained, emitting the head cell with each step, and leaves the order
// unchanged; a dump of an empty list returns a single result with no element.
// Requests are taken while no dump is running and the result register is free or drained.
module positional_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	ple_cmd_if.sink           cmd,
	ple_res_if.source         res
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        left_q;
	logic                 state_q;
	logic                 res_valid_q;
	ple_pkg::res_t        res_q;

	logic signed [31:0]   cell_val [CAPACITY];

	logic                 out_free;
	logic                 take;
	logic                 emit;
	logic                 full;
	logic [8:0]           pos9;
	logic [8:0]           cnt9;
	logic [1:0]           dec_op;
	logic [IW-1:0]        dec_at;
	logic [1:0]           dec_status;
	logic [CW-1:0]        dec_count;
	logic [1:0]           cell_op;
	logic [IW-1:0]        tail;

	assign out_free  = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign take      = cmd.valid && cmd.ready;
	assign emit      = (state_q == S_DUMP) && out_free;
	assign full      = (count_q == CW'(CAPACITY));
	assign pos9      = {1'b0, cmd.payload.position};
	assign cnt9      = 9'(count_q);
	assign tail      = IW'(count_q - CW'(1));

	always_comb begin
		dec_op     = ple_pkg::CELL_HOLD;
		dec_at     = '0;
		dec_status = ple_pkg::STAT_OK;
		dec_count  = count_q;
		unique case (cmd.payload.action)
			ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK: begin
				if (full) begin
					dec_status = ple_pkg::STAT_FULL;
				end else begin
					dec_op    = ple_pkg::CELL_INSERT;
					dec_at    = (cmd.payload.action == ple_pkg::ACT_INS_FRONT) ? '0
						: IW'(count_q);
					dec_count = count_q + CW'(1);
				end
			end
			ple_pkg::ACT_INS_AT: begin
				if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
					dec_status = ple_pkg::STAT_BADPOS;
				end else if (full) begin
					dec_status = ple_pkg::STAT_FULL;
				end else begin
					dec_op    = ple_pkg::CELL_INSERT;
					dec_at    = IW'(pos9 - 9'd1);
					dec_count = count_q + CW'(1);
				end
			end
			ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK: begin
				if (count_q == '0) begin
					dec_status = ple_pkg::STAT_EMPTY;
				end else begin
					dec_op    = ple_pkg::CELL_DELETE;
					dec_at    = (cmd.payload.action == ple_pkg::ACT_DEL_FRONT) ? '0 : tail;
					dec_count = count_q - CW'(1);
				end
			end
			ple_pkg::ACT_DEL_AT: begin
				if (pos9 == 9'd0 || pos9 > cnt9) begin
					dec_status = ple_pkg::STAT_BADPOS;
				end else begin
					dec_op    = ple_pkg::CELL_DELETE;
					dec_at    = IW'(pos9 - 9'd1);
					dec_count = count_q - CW'(1);
				end
			end
			default: begin
				dec_status = ple_pkg::STAT_OK;
			end
		endcase
	end

	always_comb begin
		priority if (take) cell_op = dec_op;
		else if (emit) cell_op = ple_pkg::CELL_ROTATE;
		else cell_op = ple_pkg::CELL_HOLD;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end
		ple_cell #(
			.IW    (IW),
			.INDEX (g)
		) u_cell (
			.clk         (clk),
			.op          (cell_op),
			.at          (dec_at),
			.tail        (tail),
			.ins_value   (cmd.payload.value),
			.left_value  (left_v),
			.right_value (right_v),
			.head_value  (cell_val[0]),
			.value       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= dec_count;
				if (cmd.payload.action == ple_pkg::ACT_DUMP && count_q != '0) begin
					state_q     <= S_DUMP;
					left_q      <= count_q;
					res_valid_q <= 1'b0;
				end else begin
					res_valid_q <= 1'b1;
				end
			end else if (emit) begin
				res_valid_q <= 1'b1;
				left_q      <= left_q - CW'(1);
				if (left_q == CW'(1)) state_q <= S_IDLE;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.status        <= dec_status;
			res_q.element_count <= 5'(dec_count);
			res_q.element_value <= '0;
			res_q.has_element   <= 1'b0;
			res_q.last          <= 1'b1;
		end else if (emit) begin
			res_q.status        <= ple_pkg::STAT_OK;
			res_q.element_count <= 5'(count_q);
			res_q.element_value <= cell_val[0];
			res_q.has_element   <= 1'b1;
			res_q.last          <= (left_q == CW'(1));
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule
